### design/stc_pkg.sv
package stc_pkg;

    localparam int CHAR_W     = 8;
    localparam int OP_W       = 2;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // LCD command codes
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SETPOS = 2'd1;
    localparam logic [OP_W-1:0] OP_HOME   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Input item kinds
    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 1'b1;
    localparam logic [4:0]           LINE_LENGTH_RST = 5'd20;
    localparam logic [1:0]           LINE_COUNT_RST  = 2'd2;

    localparam logic [POS_W-1:0] CURSOR_MAX = 6'd63;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CR_START,
        S_CR_EMIT,
        S_NL,
        S_BLANK,
        S_HOME,
        S_RD,
        S_CHR,
        S_SETPOS,
        S_PUTC
    } t_state;

endpackage

### design/stc_in_if.sv
interface stc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [stc_pkg::CHAR_W-1:0]  char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

### design/stc_out_if.sv
interface stc_out_if;
    logic                        valid;
    logic                        ready;
    logic [stc_pkg::OP_W-1:0]    lcd_op;
    logic [stc_pkg::CHAR_W-1:0]  out_char;
    logic [stc_pkg::POS_W-1:0]   position;
    logic                        last;

    modport source (output valid, output lcd_op, output out_char, output position,
                    output last, input ready);
    modport sink   (input valid, input lcd_op, input out_char, input position,
                    input last, output ready);
endinterface

### design/stc_cfg_if.sv
interface stc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [stc_pkg::CFG_IDX_W-1:0]   index;
    logic [stc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/scrolling_text_console.sv
// Printable character: accepted in idle, then the write state puts its write command in the
// output register once the output slot is free and returns to idle for the next item. Carriage
// return passes a start and an emit state; clear passes a clear and a home state. A line feed
// (or a write past the line end) sets up and blanks the new line, sends home, then redraws
// each stored character (up to capacity) through a read and a write state, as the text store
// has a single registered read port, plus a final set position once wrapped and a write for
// a pending character; output stalls hold each command state. Reset is synchronous and
// returns the store to all spaces at once through per-entry valid bits; no clearing pass.
module scrolling_text_console #(
    parameter int MAX_COLUMNS = 20,
    parameter int MAX_ROWS    = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stc_in_if.sink           i_in,
    stc_out_if.source        o_out,
    stc_cfg_if.sink          i_cfg
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam int LEN_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = (IDX_W > stc_pkg::POS_W) ? IDX_W : stc_pkg::POS_W;

    function automatic logic [LEN_W-1:0] f_eff_len(input logic [4:0] v);
        logic [LEN_W-1:0] res;
        if (v == 5'd0) begin
            res = LEN_W'(1);
        end else if (int'(v) > MAX_COLUMNS) begin
            res = LEN_W'(MAX_COLUMNS);
        end else begin
            res = LEN_W'(v);
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] f_eff_rows(input logic [1:0] v);
        logic [ROW_W-1:0] res;
        if (v == 2'd0) begin
            res = ROW_W'(1);
        end else if (int'(v) > MAX_ROWS) begin
            res = ROW_W'(MAX_ROWS);
        end else begin
            res = ROW_W'(v);
        end
        return res;
    endfunction

    function automatic logic [stc_pkg::POS_W-1:0] w_setpos_x(input logic [CMP_W-1:0] v);
        return v[stc_pkg::POS_W-1:0];
    endfunction

    stc_pkg::t_state r_state, n_state;

    logic [4:0]                  r_line_length, n_line_length;
    logic [1:0]                  r_line_count, n_line_count;
    logic [IDX_W-1:0]            r_wi, n_wi;
    logic [IDX_W-1:0]            r_line_end, n_line_end;
    logic                        r_wrapped, n_wrapped;
    logic [stc_pkg::POS_W-1:0]   r_cursor, n_cursor;
    logic [IDX_W-1:0]            r_ptr, n_ptr;
    logic [IDX_W-1:0]            r_cnt, n_cnt;
    logic [IDX_W-1:0]            r_tmp, n_tmp;
    logic [stc_pkg::CHAR_W-1:0]  r_char, n_char;
    logic                        r_pending, n_pending;
    logic [DEPTH-1:0]            r_valid, n_valid;

    logic                        r_out_valid;
    logic [stc_pkg::OP_W-1:0]    r_out_op;
    logic [stc_pkg::CHAR_W-1:0]  r_out_char;
    logic [stc_pkg::POS_W-1:0]   r_out_pos;
    logic                        r_out_last;

    logic [stc_pkg::CHAR_W-1:0]  mem [DEPTH];
    logic [stc_pkg::CHAR_W-1:0]  r_rd_data;
    logic                        r_rd_vld;

    logic [LEN_W-1:0]            w_len;
    logic [IDX_W-1:0]            w_len_x;
    logic [IDX_W-1:0]            w_cap;
    logic [CMP_W-1:0]            w_setpos_full;
    logic [IDX_W-1:0]            w_offset;
    logic [CMP_W-1:0]            w_cur_x;
    logic [CMP_W-1:0]            w_off_x;
    logic [stc_pkg::POS_W-1:0]   w_cr_pos;
    logic [IDX_W-1:0]            w_start;
    logic [IDX_W-1:0]            w_ptr_inc;
    logic                        w_slot;
    logic                        w_emit;
    logic [stc_pkg::OP_W-1:0]    w_op;
    logic [stc_pkg::CHAR_W-1:0]  w_ochar;
    logic [stc_pkg::POS_W-1:0]   w_opos;
    logic                        w_olast;
    logic                        w_mem_we;
    logic [stc_pkg::CHAR_W-1:0]  w_mem_wdata;
    logic                        w_in_ready;
    logic                        w_cfg_ready;

    assign w_len         = f_eff_len(r_line_length);
    assign w_len_x       = IDX_W'(w_len);
    assign w_cap         = w_len_x * IDX_W'(f_eff_rows(r_line_count));
    assign w_setpos_full = CMP_W'(w_cap) - CMP_W'(w_len_x);
    assign w_offset      = (r_wi >= r_tmp) ? r_wi - r_tmp : '0;
    assign w_cur_x       = CMP_W'(r_cursor);
    assign w_off_x       = CMP_W'(w_offset);
    assign w_cr_pos      = (w_cur_x >= w_off_x) ? w_setpos_x(w_cur_x - w_off_x) : '0;
    assign w_start       = (r_line_end >= w_cap) ? '0 : r_line_end;
    assign w_ptr_inc     = r_ptr + IDX_W'(1);
    assign w_slot        = !r_out_valid || o_out.ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = w_cfg_ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.lcd_op   = r_out_op;
    assign o_out.out_char = r_out_char;
    assign o_out.position = r_out_pos;
    assign o_out.last     = r_out_last;

    always_comb begin
        n_state       = r_state;
        n_line_length = r_line_length;
        n_line_count  = r_line_count;
        n_wi          = r_wi;
        n_line_end    = r_line_end;
        n_wrapped     = r_wrapped;
        n_cursor      = r_cursor;
        n_ptr         = r_ptr;
        n_cnt         = r_cnt;
        n_tmp         = r_tmp;
        n_char        = r_char;
        n_pending     = r_pending;
        n_valid       = r_valid;
        w_emit        = 1'b0;
        w_op          = stc_pkg::OP_WRITE;
        w_ochar       = '0;
        w_opos        = '0;
        w_olast       = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_wdata   = stc_pkg::CH_SPACE;
        w_in_ready    = 1'b0;
        w_cfg_ready   = 1'b0;

        unique case (r_state)
            stc_pkg::S_IDLE: begin
                w_cfg_ready = 1'b1;
                w_in_ready  = !i_cfg.valid;
                if (i_cfg.valid) begin
                    unique case (i_cfg.index)
                        stc_pkg::CFG_LINE_LENGTH: begin
                            n_line_length = i_cfg.data;
                            n_line_end    = IDX_W'(f_eff_len(i_cfg.data));
                        end
                        stc_pkg::CFG_LINE_COUNT: begin
                            n_line_count = i_cfg.data[1:0];
                            n_line_end   = w_len_x;
                        end
                        default: begin
                            n_line_end = w_len_x;
                        end
                    endcase
                    n_valid   = '0;
                    n_wi      = '0;
                    n_wrapped = 1'b0;
                end else if (i_in.valid) begin
                    if (i_in.kind == stc_pkg::KIND_CLEAR) begin
                        n_valid    = '0;
                        n_wi       = '0;
                        n_line_end = w_len_x;
                        n_wrapped  = 1'b0;
                        n_pending  = 1'b0;
                        n_state    = stc_pkg::S_CLR;
                    end else begin
                        case (i_in.char_code)
                            stc_pkg::CH_CR: begin
                                n_state = stc_pkg::S_CR_START;
                            end
                            stc_pkg::CH_LF: begin
                                n_pending = 1'b0;
                                n_state   = stc_pkg::S_NL;
                            end
                            default: begin
                                n_char = i_in.char_code;
                                if (r_wi >= r_line_end) begin
                                    n_pending = 1'b1;
                                    n_state   = stc_pkg::S_NL;
                                end else begin
                                    n_state = stc_pkg::S_PUTC;
                                end
                            end
                        endcase
                    end
                end
            end
            stc_pkg::S_CLR: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_op    = stc_pkg::OP_CLEAR;
                    n_state = stc_pkg::S_HOME;
                end
            end
            stc_pkg::S_CR_START: begin
                n_tmp   = (r_line_end >= w_len_x) ? r_line_end - w_len_x : '0;
                n_state = stc_pkg::S_CR_EMIT;
            end
            stc_pkg::S_CR_EMIT: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_op    = stc_pkg::OP_SETPOS;
                    w_opos  = w_cr_pos;
                    w_olast = 1'b1;
                    n_wi    = r_tmp;
                    n_state = stc_pkg::S_IDLE;
                end
            end
            stc_pkg::S_NL: begin
                if (r_line_end >= w_cap) begin
                    n_wrapped = 1'b1;
                end
                n_wi       = w_start;
                n_ptr      = w_start;
                n_cnt      = w_len_x;
                n_line_end = w_start + w_len_x;
                n_state    = stc_pkg::S_BLANK;
            end
            stc_pkg::S_BLANK: begin
                // Blank the new line one entry per cycle before it is redrawn.
                w_mem_we                 = 1'b1;
                w_mem_wdata              = stc_pkg::CH_SPACE;
                n_valid[r_ptr[AW-1:0]]   = 1'b1;
                n_ptr                    = w_ptr_inc;
                n_cnt                    = r_cnt - IDX_W'(1);
                if (r_cnt == IDX_W'(1)) begin
                    n_state = stc_pkg::S_HOME;
                end
            end
            stc_pkg::S_HOME: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_op    = stc_pkg::OP_HOME;
                    w_olast = !r_wrapped && (r_wi == '0) && !r_pending;
                    if (r_wrapped) begin
                        // Oldest line sits just past the current line end.
                        n_ptr   = (r_line_end == w_cap) ? '0 : r_line_end;
                        n_cnt   = w_cap;
                        n_state = stc_pkg::S_RD;
                    end else begin
                        n_ptr = '0;
                        n_cnt = r_wi;
                        if (r_wi != '0) begin
                            n_state = stc_pkg::S_RD;
                        end else if (r_pending) begin
                            n_state = stc_pkg::S_PUTC;
                        end else begin
                            n_state = stc_pkg::S_IDLE;
                        end
                    end
                end
            end
            stc_pkg::S_RD: begin
                n_state = stc_pkg::S_CHR;
            end
            stc_pkg::S_CHR: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_op    = stc_pkg::OP_WRITE;
                    w_ochar = r_rd_vld ? r_rd_data : stc_pkg::CH_SPACE;
                    w_olast = (r_cnt == IDX_W'(1)) && !r_wrapped && !r_pending;
                    n_ptr   = (w_ptr_inc == w_cap) ? '0 : w_ptr_inc;
                    n_cnt   = r_cnt - IDX_W'(1);
                    if (r_cnt != IDX_W'(1)) begin
                        n_state = stc_pkg::S_RD;
                    end else if (r_wrapped) begin
                        n_state = stc_pkg::S_SETPOS;
                    end else if (r_pending) begin
                        n_state = stc_pkg::S_PUTC;
                    end else begin
                        n_state = stc_pkg::S_IDLE;
                    end
                end
            end
            stc_pkg::S_SETPOS: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_op    = stc_pkg::OP_SETPOS;
                    w_opos  = w_setpos_x(w_setpos_full);
                    w_olast = !r_pending;
                    n_state = r_pending ? stc_pkg::S_PUTC : stc_pkg::S_IDLE;
                end
            end
            stc_pkg::S_PUTC: begin
                if (w_slot) begin
                    w_emit                = 1'b1;
                    w_op                  = stc_pkg::OP_WRITE;
                    w_ochar               = r_char;
                    w_olast               = 1'b1;
                    w_mem_we              = 1'b1;
                    w_mem_wdata           = r_char;
                    n_valid[r_wi[AW-1:0]] = 1'b1;
                    n_wi                  = r_wi + IDX_W'(1);
                    n_pending             = 1'b0;
                    n_state               = stc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stc_pkg::S_IDLE;
            end
        endcase

        // Track the LCD cursor from each command sent.
        if (w_emit) begin
            unique case (w_op)
                stc_pkg::OP_WRITE: begin
                    if (r_cursor != stc_pkg::CURSOR_MAX) begin
                        n_cursor = r_cursor + stc_pkg::POS_W'(1);
                    end
                end
                stc_pkg::OP_SETPOS: begin
                    n_cursor = w_opos;
                end
                default: begin
                    n_cursor = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= stc_pkg::S_IDLE;
            r_line_length <= stc_pkg::LINE_LENGTH_RST;
            r_line_count  <= stc_pkg::LINE_COUNT_RST;
            r_wi          <= '0;
            r_line_end    <= IDX_W'(f_eff_len(stc_pkg::LINE_LENGTH_RST));
            r_wrapped     <= 1'b0;
            r_cursor      <= '0;
            r_ptr         <= '0;
            r_cnt         <= '0;
            r_tmp         <= '0;
            r_pending     <= 1'b0;
            r_valid       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_line_length <= n_line_length;
            r_line_count  <= n_line_count;
            r_wi          <= n_wi;
            r_line_end    <= n_line_end;
            r_wrapped     <= n_wrapped;
            r_cursor      <= n_cursor;
            r_ptr         <= n_ptr;
            r_cnt         <= n_cnt;
            r_tmp         <= n_tmp;
            r_pending     <= n_pending;
            r_valid       <= n_valid;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        if (w_emit) begin
            r_out_op   <= w_op;
            r_out_char <= w_ochar;
            r_out_pos  <= w_opos;
            r_out_last <= w_olast;
        end
    end

    // Text store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            if (r_state == stc_pkg::S_PUTC) begin
                mem[r_wi[AW-1:0]] <= w_mem_wdata;
            end else begin
                mem[r_ptr[AW-1:0]] <= w_mem_wdata;
            end
        end
        r_rd_data <= mem[r_ptr[AW-1:0]];
        r_rd_vld  <= r_valid[r_ptr[AW-1:0]];
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again right after a transfer");

    a_wi_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wi <= r_line_end)
        else $error("write index past the current line end");

    a_line_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_end <= w_cap)
        else $error("line end beyond store capacity");

    a_burst_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |-> (r_state != stc_pkg::S_IDLE))
        else $error("burst ended without a final command");

endmodule

### dv/scrolling_text_console_test.sv
`timescale 1ns / 1ps

module scrolling_text_console_test;

    localparam int MAX_COLUMNS   = 20;
    localparam int MAX_ROWS      = 2;
    localparam int STORE_DEPTH   = MAX_COLUMNS * MAX_ROWS;
    localparam int IDLE_PCT      = 28;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_CYCLES  = 600;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic                       kind;
        logic [stc_pkg::CHAR_W-1:0] code;
    } t_console_req;

    typedef struct packed {
        logic [stc_pkg::OP_W-1:0]   op;
        logic [stc_pkg::CHAR_W-1:0] ch;
        logic [stc_pkg::POS_W-1:0]  pos;
        logic                       last;
    } t_lcd_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_off = 1'b0;
    bit   calm = 1'b0;
    bit   pressure_go = 1'b0;
    int   errors = 0;
    int   cycles = 0;

    // Shadow copy of the console state and its registers.
    logic [stc_pkg::CHAR_W-1:0] shadow_text [STORE_DEPTH];
    int                         cursor_slot;
    int                         line_stop;
    int                         lcd_cursor;
    bit                         ring_full;
    logic [4:0]                 len_setting;
    logic [1:0]                 rows_setting;

    t_console_req pending_reqs[$];
    t_lcd_cmd     lcd_expect[$];

    stc_in_if  in_bus ();
    stc_out_if out_bus ();
    stc_cfg_if cfg_bus ();

    scrolling_text_console #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS(MAX_ROWS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_bus),
        .o_out(out_bus),
        .i_cfg(cfg_bus)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int cols_used();
        int v = int'(len_setting);
        if (v < 1) v = 1;
        if (v > MAX_COLUMNS) v = MAX_COLUMNS;
        return v;
    endfunction

    function automatic int slots_used();
        int r = int'(rows_setting);
        if (r < 1) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return cols_used() * r;
    endfunction

    function automatic void issue(logic [stc_pkg::OP_W-1:0] op, int ch, int pos);
        t_lcd_cmd cmd;
        cmd.op   = op;
        cmd.ch   = (op == stc_pkg::OP_WRITE) ? ch[stc_pkg::CHAR_W-1:0] : '0;
        cmd.pos  = (op == stc_pkg::OP_SETPOS) ? pos[stc_pkg::POS_W-1:0] : '0;
        cmd.last = 1'b0;
        lcd_expect.push_back(cmd);
        if (op == stc_pkg::OP_WRITE) begin
            if (lcd_cursor < int'(stc_pkg::CURSOR_MAX)) lcd_cursor++;
        end else if (op == stc_pkg::OP_SETPOS) begin
            lcd_cursor = int'(cmd.pos);
        end else begin
            lcd_cursor = 0;
        end
    endfunction

    function automatic void blank_console();
        foreach (shadow_text[i]) shadow_text[i] = stc_pkg::CH_SPACE;
        cursor_slot = 0;
        line_stop   = cols_used();
        ring_full   = 1'b0;
    endfunction

    // A redraw walks the ring oldest line first.
    function automatic void redraw();
        int cap;
        int i;
        cap = slots_used();
        issue(stc_pkg::OP_HOME, 0, 0);
        if (ring_full) begin
            for (i = line_stop; i < cap; i++)
                issue(stc_pkg::OP_WRITE, int'(shadow_text[i]), 0);
            for (i = 0; i < line_stop && i < cap; i++)
                issue(stc_pkg::OP_WRITE, int'(shadow_text[i]), 0);
            issue(stc_pkg::OP_SETPOS, 0, cap - cols_used());
        end else begin
            for (i = 0; i < cursor_slot && i < cap; i++)
                issue(stc_pkg::OP_WRITE, int'(shadow_text[i]), 0);
        end
    endfunction

    function automatic void open_line();
        int len;
        int start;
        int i;
        len   = cols_used();
        start = line_stop;
        if (start >= slots_used()) begin
            ring_full = 1'b1;
            start     = 0;
        end
        cursor_slot = start;
        for (i = start; i < start + len; i++) begin
            if (i < STORE_DEPTH) shadow_text[i] = stc_pkg::CH_SPACE;
        end
        line_stop = start + len;
        redraw();
    endfunction

    function automatic void predict_console(t_console_req req);
        int len;
        int line_start;
        int offset;
        int pos;
        t_lcd_cmd tail;
        if (req.kind == stc_pkg::KIND_CLEAR) begin
            blank_console();
            issue(stc_pkg::OP_CLEAR, 0, 0);
            redraw();
        end else if (req.code == stc_pkg::CH_CR) begin
            len        = cols_used();
            line_start = (line_stop >= len) ? line_stop - len : 0;
            offset     = (cursor_slot >= line_start) ? cursor_slot - line_start : 0;
            pos        = (lcd_cursor >= offset) ? lcd_cursor - offset : 0;
            cursor_slot = line_start;
            issue(stc_pkg::OP_SETPOS, 0, pos);
        end else if (req.code == stc_pkg::CH_LF) begin
            open_line();
        end else begin
            if (cursor_slot >= line_stop) open_line();
            if (cursor_slot < STORE_DEPTH) shadow_text[cursor_slot] = req.code;
            cursor_slot++;
            issue(stc_pkg::OP_WRITE, int'(req.code), 0);
        end
        tail = lcd_expect.pop_back();
        tail.last = 1'b1;
        lcd_expect.push_back(tail);
    endfunction

    function automatic void apply_reg(logic [stc_pkg::CFG_IDX_W-1:0] idx,
                                      logic [stc_pkg::CFG_DATA_W-1:0] value);
        if (idx == stc_pkg::CFG_LINE_LENGTH) begin
            len_setting = value[4:0];
        end else begin
            rows_setting = value[1:0];
        end
        blank_console();
    endfunction

    function automatic t_console_req random_req();
        t_console_req r;
        int pick = $urandom_range(99);
        r.kind = stc_pkg::KIND_CHAR;
        r.code = 8'($urandom_range(255));
        if (pick < 6) begin
            r.kind = stc_pkg::KIND_CLEAR;
        end else if (pick < 16) begin
            r.code = stc_pkg::CH_CR;
        end else if (pick < 26) begin
            r.code = stc_pkg::CH_LF;
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) flag_error($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    task automatic send(input logic kind, input logic [stc_pkg::CHAR_W-1:0] code);
        t_console_req r;
        r.kind = kind;
        r.code = code;
        pending_reqs.push_back(r);
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || in_bus.valid || lcd_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [stc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [stc_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        apply_reg(idx, value);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        repeat (n) pending_reqs.push_back(random_req());
        settle();
    endtask

    // Input driver: holds an offered item until its transfer completes.
    always @(posedge i_clk) begin
        if (in_bus.valid && in_bus.ready) predict_console(pending_reqs.pop_front());
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!(in_bus.valid && !in_bus.ready)) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                in_bus.valid     <= 1'b1;
                in_bus.kind      <= pending_reqs[0].kind;
                in_bus.char_code <= pending_reqs[0].code;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Output monitor and receiver.
    always @(posedge i_clk) begin
        t_lcd_cmd want;
        if (out_bus.valid === 1'b1 && out_bus.ready) begin
            if (lcd_expect.size() == 0) begin
                flag_error($sformatf("unexpected command op=%0d char=%0h pos=%0d",
                                     out_bus.lcd_op, out_bus.out_char, out_bus.position));
            end else begin
                want = lcd_expect.pop_front();
                check_field("lcd_op", 8'(out_bus.lcd_op), 8'(want.op));
                check_field("out_char", out_bus.out_char, want.ch);
                check_field("position", 8'(out_bus.position), 8'(want.pos));
                check_field("last", 8'(out_bus.last), 8'(want.last));
            end
        end
        out_bus.ready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // Long receiver hold-off so that the block backs up into its input.
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.kind       = stc_pkg::KIND_CHAR;
        in_bus.char_code  = '0;
        out_bus.ready     = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = stc_pkg::CFG_LINE_LENGTH;
        cfg_bus.data      = '0;
        len_setting  = stc_pkg::LINE_LENGTH_RST;
        rows_setting = stc_pkg::LINE_COUNT_RST;
        lcd_cursor   = 0;
        blank_console();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: byte extremes, return, feed, clear with a stray code.
        send(stc_pkg::KIND_CHAR, 8'h00);
        send(stc_pkg::KIND_CHAR, 8'hFF);
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_CR);
        send(stc_pkg::KIND_CHAR, "Q");
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_LF);
        send(stc_pkg::KIND_CLEAR, 8'hFF);
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_LF);
        settle();

        // One short line: writing past the end wraps the ring at once.
        write_reg(stc_pkg::CFG_LINE_LENGTH, 5'd3);
        write_reg(stc_pkg::CFG_LINE_COUNT, 5'd1);
        send(stc_pkg::KIND_CHAR, "a");
        send(stc_pkg::KIND_CHAR, "b");
        send(stc_pkg::KIND_CHAR, "c");
        send(stc_pkg::KIND_CHAR, "d");
        send(stc_pkg::KIND_CHAR, "e");
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_CR);
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_CR);
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_LF);
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_CR);
        settle();

        write_reg(stc_pkg::CFG_LINE_LENGTH, 5'd2);
        write_reg(stc_pkg::CFG_LINE_COUNT, 5'd2);
        send(stc_pkg::KIND_CHAR, "w");
        send(stc_pkg::KIND_CHAR, "x");
        send(stc_pkg::KIND_CHAR, "y");
        send(stc_pkg::KIND_CHAR, "z");
        send(stc_pkg::KIND_CHAR, "v");
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_LF);
        send(stc_pkg::KIND_CLEAR, stc_pkg::CH_CR);
        settle();

        // Zero in both registers acts as one column and one row.
        write_reg(stc_pkg::CFG_LINE_LENGTH, 5'd0);
        write_reg(stc_pkg::CFG_LINE_COUNT, 5'd0);
        send(stc_pkg::KIND_CHAR, "k");
        send(stc_pkg::KIND_CHAR, "m");
        send(stc_pkg::KIND_CHAR, stc_pkg::CH_CR);
        settle();

        write_reg(stc_pkg::CFG_LINE_LENGTH, 5'd20);
        write_reg(stc_pkg::CFG_LINE_COUNT, 5'd2);
        pressure_go = 1'b1;
        random_phase(30);

        // Values above the range clamp to the full geometry; no idling here.
        write_reg(stc_pkg::CFG_LINE_LENGTH, 5'd31);
        write_reg(stc_pkg::CFG_LINE_COUNT, 5'd31);
        calm = 1'b1;
        random_phase(25);
        calm = 1'b0;

        write_reg(stc_pkg::CFG_LINE_LENGTH, 5'($urandom_range(20, 1)));
        write_reg(stc_pkg::CFG_LINE_COUNT, 5'($urandom_range(31)));
        random_phase(25);

        write_reg(stc_pkg::CFG_LINE_COUNT, 5'd2);
        write_reg(stc_pkg::CFG_LINE_LENGTH, 5'($urandom_range(6)));
        random_phase(25);

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
